// ===== hw/rtl/http_body_dechunker_top_assert.svh =====
// assertion macros for the http body dechunker checker
// expects clk and rst in the scope where a macro is used
`ifndef HTTP_BODY_DECHUNKER_TOP_ASSERT_SVH
`define HTTP_BODY_DECHUNKER_TOP_ASSERT_SVH

// same-cycle implication
`define HBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbd checker: property failed");

// next-cycle implication
`define HBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbd checker: property failed");

`endif

// ===== hw/rtl/hbd_pkg.sv =====
// shared types, constants and helpers of the http body dechunker
// no dependencies
`timescale 1ns / 1ps

package hbd_pkg;

  localparam int DEFAULT_COUNT_BITS = 32;
  localparam int CFG_ADDR_BITS      = 4;
  localparam int CFG_DATA_BITS      = 32;
  localparam int HEX_RADIX          = 16;

  // register indexes
  localparam logic [1:0] REG_TRANSFER_MODE  = 2'd0;
  localparam logic [1:0] REG_CONTENT_LENGTH = 2'd1;
  localparam logic [1:0] REG_LIMIT_ENABLE   = 2'd2;
  localparam logic [1:0] REG_MAX_BODY_SIZE  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_FRAMING   = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

  // characters
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_F  = 8'h66;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_F   = 8'h46;

  typedef enum logic [4:0] {
    PH_LINE = 5'b00001,
    PH_DATA = 5'b00010,
    PH_TCR  = 5'b00100,
    PH_TLF  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        transfer_mode;
    logic [31:0] content_length;
    logic        limit_enable;
    logic [31:0] max_body_size;
  } cfg_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r = {1'b1, 4'(c - CHAR_ZERO)};
    end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
      r = {1'b1, 4'(c - CHAR_LOW_A + 8'd10)};
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      r = {1'b1, 4'(c - CHAR_UP_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hbd_if.sv =====
// stream interfaces: raw byte words in, result words out
// depends on hbd_pkg
`timescale 1ns / 1ps

interface hbd_byte_if import hbd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hbd_result_if import hbd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        body_valid;
  logic [7:0]  body_byte;
  logic        body_done;
  logic [1:0]  error_code;
  logic [31:0] bytes_received;

  modport source (output valid, output body_valid, output body_byte, output body_done,
                  output error_code, output bytes_received, input ready);
  modport sink (input valid, input body_valid, input body_byte, input body_done,
                input error_code, input bytes_received, output ready);
endinterface

// ===== hw/rtl/hbd_regs.sv =====
// apb configuration registers of the dechunker
// depends on hbd_pkg
`timescale 1ns / 1ps

module hbd_regs import hbd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  logic [1:0] reg_index;

  assign reg_index = paddr[CFG_ADDR_BITS-1:2];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        REG_TRANSFER_MODE:  cfg.transfer_mode  <= pwdata[0];
        REG_CONTENT_LENGTH: cfg.content_length <= pwdata;
        REG_LIMIT_ENABLE:   cfg.limit_enable   <= pwdata[0];
        REG_MAX_BODY_SIZE:  cfg.max_body_size  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_TRANSFER_MODE:  prdata = {31'd0, cfg.transfer_mode};
      REG_CONTENT_LENGTH: prdata = cfg.content_length;
      REG_LIMIT_ENABLE:   prdata = {31'd0, cfg.limit_enable};
      REG_MAX_BODY_SIZE:  prdata = cfg.max_body_size;
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/hbd_core.sv =====
// byte pipeline: input register, framing state update, result register
// depends on hbd_pkg and hbd_if
`timescale 1ns / 1ps

module hbd_core import hbd_pkg::*; #(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  hbd_byte_if.sink     byte_in,
  hbd_result_if.source body_out
);

  localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  // input stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  // framing state
  phase_t                phase, phase_next;
  logic [31:0]           chunk_size, chunk_size_next;
  logic [31:0]           chunk_left, chunk_left_next;
  logic                  digits_ended, digits_ended_next;
  logic                  saw_cr, saw_cr_next;
  logic [COUNT_BITS-1:0] received_count, received_count_next;
  logic [1:0]            error_state, error_state_next;

  // step logic
  phase_t                cur;
  logic                  fwd;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CMP_W-1:0]      count_wide, inc_wide, next_wide;
  logic [4:0]            hex;

  assign advance      = !body_out.valid || body_out.ready;
  assign byte_in.ready = !in_valid || advance;

  assign count_inc  = (received_count == '1) ? received_count : received_count + 1'b1;
  assign count_wide = CMP_W'(received_count);
  assign inc_wide   = CMP_W'(count_inc);
  assign next_wide  = CMP_W'(received_count_next);
  assign hex        = hex_digit(in_byte);

  always_comb begin
    phase_next          = phase;
    chunk_size_next     = chunk_size;
    chunk_left_next     = chunk_left;
    digits_ended_next   = digits_ended;
    saw_cr_next         = saw_cr;
    received_count_next = received_count;
    error_state_next    = error_state;
    fwd                 = 1'b0;

    // stray codes read as the start of a size line
    case (phase)
      PH_LINE, PH_DATA, PH_TCR, PH_TLF, PH_DONE: cur = phase;
      default:                                   cur = PH_LINE;
    endcase

    if (error_state == ERR_NONE && cur != PH_DONE) begin
      if (cfg.transfer_mode) begin
        // exhausted data run means the trailer is due
        if (cur == PH_DATA && chunk_left == 32'd0) cur = PH_TCR;
        phase_next = cur;
        case (cur)
          PH_DATA: begin
            fwd                 = 1'b1;
            received_count_next = count_inc;
            chunk_left_next     = chunk_left - 32'd1;
            if (chunk_left == 32'd1) begin
              if (cfg.limit_enable && inc_wide > CMP_W'(cfg.max_body_size)) begin
                error_state_next = ERR_TOO_LARGE;
              end else begin
                phase_next = PH_TCR;
              end
            end
          end
          PH_TCR: begin
            if (in_byte != CHAR_CR) error_state_next = ERR_FRAMING;
            else phase_next = PH_TLF;
          end
          PH_TLF: begin
            if (in_byte != CHAR_LF) begin
              error_state_next = ERR_FRAMING;
            end else begin
              phase_next        = PH_LINE;
              chunk_size_next   = 32'd0;
              digits_ended_next = 1'b0;
              saw_cr_next       = 1'b0;
            end
          end
          default: begin
            phase_next = PH_LINE;
            if (saw_cr && in_byte == CHAR_LF) begin
              if (chunk_size == 32'd0) begin
                phase_next = PH_DONE;
              end else begin
                chunk_left_next = chunk_size;
                phase_next      = PH_DATA;
              end
              chunk_size_next   = 32'd0;
              digits_ended_next = 1'b0;
              saw_cr_next       = 1'b0;
            end else begin
              saw_cr_next = (in_byte == CHAR_CR);
              if (!digits_ended) begin
                if (!hex[4]) begin
                  digits_ended_next = 1'b1;
                end else if (chunk_size[31:28] != 4'd0) begin
                  chunk_size_next = '1;
                end else begin
                  chunk_size_next = {chunk_size[31-$clog2(HEX_RADIX):0], hex[3:0]};
                end
              end
            end
          end
        endcase
      end else begin
        if (cur != PH_DATA && cfg.limit_enable && cfg.content_length > cfg.max_body_size) begin
          error_state_next = ERR_TOO_LARGE;
          phase_next       = cur;
        end else if (count_wide >= CMP_W'(cfg.content_length)) begin
          phase_next = PH_DONE;
        end else begin
          fwd                 = 1'b1;
          received_count_next = count_inc;
          phase_next = (inc_wide == CMP_W'(cfg.content_length)) ? PH_DONE : PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) in_byte <= byte_in.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      body_out.valid <= 1'b0;
      phase          <= PH_LINE;
      chunk_size     <= '0;
      chunk_left     <= '0;
      digits_ended   <= 1'b0;
      saw_cr         <= 1'b0;
      received_count <= '0;
      error_state    <= ERR_NONE;
    end else if (advance) begin
      body_out.valid <= in_valid;
      if (in_valid) begin
        phase          <= phase_next;
        chunk_size     <= chunk_size_next;
        chunk_left     <= chunk_left_next;
        digits_ended   <= digits_ended_next;
        saw_cr         <= saw_cr_next;
        received_count <= received_count_next;
        error_state    <= error_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      body_out.body_valid     <= fwd;
      body_out.body_byte      <= fwd ? in_byte : 8'd0;
      body_out.body_done      <= (error_state_next == ERR_NONE) && (phase_next == PH_DONE);
      body_out.error_code     <= error_state_next;
      body_out.bytes_received <= (next_wide > CMP_W'({32{1'b1}})) ? '1 : next_wide[31:0];
    end
  end

endmodule

// ===== hw/rtl/http_body_dechunker_top.sv =====
// a byte word accepted into the input register goes through the state update into the result register
// throughput: one byte word per cycle while the result port is not stalled, set by the
// state update between the input register and the result register
// reset (rst, synchronous, active high) clears registers, framing state,
// counters, errors and both pipeline valids; no clearing pass is needed
`timescale 1ns / 1ps

// top level of the http body dechunker
// depends on hbd_pkg, hbd_if, hbd_regs and hbd_core
module http_body_dechunker_top import hbd_pkg::*; #(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS  // width of the payload byte counter
) (
  input  logic                     clk,
  input  logic                     rst,
  // apb configuration port, registers at byte address 4 * index
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  // raw body byte words in
  hbd_byte_if.sink                 byte_in,
  // one result word per accepted byte word
  hbd_result_if.source             body_out
);

  // configuration; the user keeps it stable while the stream is idle, the block does not enforce it
  cfg_t cfg;

  hbd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register, framing update and result register; the input register
  // takes one more word while a result word waits on the output
  hbd_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .byte_in  (byte_in),
    .body_out (body_out)
  );

endmodule

// ===== hw/rtl/hbd_checker.sv =====
// port-level checks of the dechunker result stream, bound to the top level
// depends on http_body_dechunker_top_assert.svh
`timescale 1ns / 1ps
`include "http_body_dechunker_top_assert.svh"

module hbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        body_valid,
  input logic [7:0]  body_byte,
  input logic        body_done,
  input logic [1:0]  error_code,
  input logic [31:0] bytes_received
);

  logic        out_acc;
  logic [43:0] out_word;

  assign out_acc  = out_valid && out_ready;
  assign out_word = {body_valid, body_byte, body_done, error_code, bytes_received};

  // stalled result word holds
  `HBD_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // errors stay once reported
  `HBD_ASSERT_IMP(a_err_sticky, (out_acc && error_code != 2'd0) ##1 out_acc, error_code == $past(error_code))

  // done stays once reported
  `HBD_ASSERT_IMP(a_done_sticky, (out_acc && body_done) ##1 out_acc, body_done)

  // byte count never goes back
  `HBD_ASSERT_IMP(a_count_mono, out_acc ##1 out_acc, bytes_received >= $past(bytes_received))

endmodule

bind http_body_dechunker_top hbd_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (body_out.valid),
  .out_ready      (body_out.ready),
  .body_valid     (body_out.body_valid),
  .body_byte      (body_out.body_byte),
  .body_done      (body_out.body_done),
  .error_code     (body_out.error_code),
  .bytes_received (body_out.bytes_received)
);
